// ----- sv/pcc_pkg.sv -----
// Shared types, constants and register codes for the pretrigger capture controller.
// Used by every module of the block; depends on nothing else.
package pcc_pkg;

    localparam int LOOKBACK_MAX = 32;
    localparam int RING_AW      = (LOOKBACK_MAX > 1) ? $clog2(LOOKBACK_MAX) : 1;
    localparam int CNT_W        = $clog2(LOOKBACK_MAX + 1);

    localparam int TAG_W    = 48;
    localparam int CMD_W    = 2;
    localparam int KIND_W   = 3;
    localparam int MASK_W   = 3;
    localparam int DEPTH_W  = 6;
    localparam int FRAMES_W = 16;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int SUSER_W  = CMD_W + 1;

    // Input event codes.
    localparam logic [CMD_W-1:0] CMD_FRAME    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DETECT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EFFECTOR = 2'd2;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [ADDR_W-3:0] REG_MASK   = 2'd0;
    localparam logic [ADDR_W-3:0] REG_DEPTH  = 2'd1;
    localparam logic [ADDR_W-3:0] REG_FRAMES = 2'd2;

    localparam logic [MASK_W-1:0]   MASK_RST   = 3'd7;
    localparam logic [DEPTH_W-1:0]  DEPTH_RST  = 6'd16;
    localparam logic [FRAMES_W-1:0] FRAMES_RST = 16'd30;

    typedef enum logic [KIND_W-1:0] {
        KIND_START    = 3'd0,
        KIND_FRAME    = 3'd1,
        KIND_DETECT   = 3'd2,
        KIND_EFFECTOR = 3'd3,
        KIND_END      = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EMIT_FRAME,
        ST_EMIT_END,
        ST_EMIT_START,
        ST_FLUSH,
        ST_EMIT_DETECT,
        ST_EMIT_EFFECTOR
    } state_t;

    typedef enum logic [1:0] {
        SRC_ITEM,
        SRC_RING,
        SRC_ZERO
    } src_t;

    typedef struct packed {
        logic [MASK_W-1:0]   mask;
        logic [DEPTH_W-1:0]  depth;
        logic [FRAMES_W-1:0] post_frames;
    } cfg_t;

    typedef struct packed {
        logic  latch_item;
        logic  push;
        logic  frame_dec;
        logic  close_clip;
        logic  detect_load;
        logic  open_flush;
        logic  flush_adv;
        logic  out_load;
        kind_t out_kind;
        src_t  out_src;
        logic  out_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             frame_ok;
        logic             detect_ok;
        logic             effector_ok;
        logic             clip_open;
        logic             frames_zero;
        logic             frames_one;
        logic             flush_zero;
        logic             flush_one;
        logic             out_free;
    } ctrl_status_t;

endpackage

// ----- sv/pcc_regs.sv -----
// Configuration register file of the pretrigger capture controller, APB-style port.
// Depends on pcc_pkg for widths, register indexes and reset values.
module pcc_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pcc_pkg::ADDR_W-1:0] paddr,
    input  logic [pcc_pkg::DATA_W-1:0] pwdata,
    output logic [pcc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output pcc_pkg::cfg_t              cfg
);
    import pcc_pkg::*;

    logic [MASK_W-1:0]   mask_reg;
    logic [DEPTH_W-1:0]  depth_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic [ADDR_W-3:0]   reg_idx;
    logic                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg   <= MASK_RST;
            depth_reg  <= DEPTH_RST;
            frames_reg <= FRAMES_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MASK:   mask_reg   <= pwdata[MASK_W-1:0];
                REG_DEPTH:  depth_reg  <= pwdata[DEPTH_W-1:0];
                REG_FRAMES: frames_reg <= pwdata[FRAMES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MASK:   prdata = DATA_W'(mask_reg);
            REG_DEPTH:  prdata = DATA_W'(depth_reg);
            REG_FRAMES: prdata = DATA_W'(frames_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.mask        = mask_reg;
    assign cfg.depth       = depth_reg;
    assign cfg.post_frames = frames_reg;

endmodule

// ----- sv/pcc_ctrl.sv -----
// Control state machine of the pretrigger capture controller.
// Depends on pcc_pkg; drives the datapath through ctrl_cmd_t and reads ctrl_status_t.
module pcc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pcc_pkg::ctrl_status_t st,
    output pcc_pkg::ctrl_cmd_t    ctl
);
    import pcc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                state_next = ST_IDLE;
                case (st.cmd)
                    CMD_FRAME: begin
                        if (st.frame_ok && st.clip_open) begin
                            state_next = st.frames_zero ? ST_EMIT_END : ST_EMIT_FRAME;
                        end
                    end
                    CMD_DETECT: begin
                        if (st.detect_ok) begin
                            state_next = st.clip_open ? ST_EMIT_DETECT : ST_EMIT_START;
                        end
                    end
                    CMD_EFFECTOR: begin
                        if (st.effector_ok && st.clip_open) state_next = ST_EMIT_EFFECTOR;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_EMIT_FRAME: begin
                // The countdown hitting zero on this frame closes the clip right after it.
                if (st.out_free) state_next = st.frames_one ? ST_EMIT_END : ST_IDLE;
            end
            ST_EMIT_END: begin
                if (st.out_free) state_next = ST_IDLE;
            end
            ST_EMIT_START: begin
                if (st.out_free) state_next = st.flush_zero ? ST_EMIT_DETECT : ST_FLUSH;
            end
            ST_FLUSH: begin
                if (st.out_free && st.flush_one) state_next = ST_EMIT_DETECT;
            end
            ST_EMIT_DETECT: begin
                if (st.out_free) state_next = ST_IDLE;
            end
            ST_EMIT_EFFECTOR: begin
                if (st.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl          = '0;
        ctl.out_kind = KIND_START;
        ctl.out_src  = SRC_ZERO;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready       = 1'b1;
                ctl.latch_item = in_valid;
            end
            ST_DISPATCH: begin
                ctl.push        = (st.cmd == CMD_FRAME) && st.frame_ok;
                ctl.detect_load = (st.cmd == CMD_DETECT) && st.detect_ok;
                ctl.open_flush  = (st.cmd == CMD_DETECT) && st.detect_ok && !st.clip_open;
            end
            ST_EMIT_FRAME: begin
                ctl.out_load  = st.out_free;
                ctl.frame_dec = st.out_free;
                ctl.out_kind  = KIND_FRAME;
                ctl.out_src   = SRC_ITEM;
                ctl.out_last  = !st.frames_one;
            end
            ST_EMIT_END: begin
                ctl.out_load   = st.out_free;
                ctl.close_clip = st.out_free;
                ctl.out_kind   = KIND_END;
                ctl.out_src    = SRC_ZERO;
                ctl.out_last   = 1'b1;
            end
            ST_EMIT_START: begin
                ctl.out_load = st.out_free;
                ctl.out_kind = KIND_START;
                ctl.out_src  = SRC_ZERO;
            end
            ST_FLUSH: begin
                ctl.out_load  = st.out_free;
                ctl.flush_adv = st.out_free;
                ctl.out_kind  = KIND_FRAME;
                ctl.out_src   = SRC_RING;
            end
            ST_EMIT_DETECT: begin
                ctl.out_load = st.out_free;
                ctl.out_kind = KIND_DETECT;
                ctl.out_src  = SRC_ITEM;
                ctl.out_last = 1'b1;
            end
            ST_EMIT_EFFECTOR: begin
                ctl.out_load = st.out_free;
                ctl.out_kind = KIND_EFFECTOR;
                ctl.out_src  = SRC_ITEM;
                ctl.out_last = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ----- sv/pcc_dp.sv -----
// Datapath of the pretrigger capture controller: item latch, lookback ring memory,
// clip counters and the output register. Depends on pcc_pkg; commanded by pcc_ctrl.
module pcc_dp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  pcc_pkg::cfg_t              cfg,
    input  pcc_pkg::ctrl_cmd_t         ctl,
    output pcc_pkg::ctrl_status_t      st,
    input  logic [pcc_pkg::CMD_W-1:0]  in_cmd,
    input  logic [pcc_pkg::TAG_W-1:0]  in_tag,
    input  logic                       in_present,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [pcc_pkg::TAG_W-1:0]  m_tdata,
    output logic [pcc_pkg::KIND_W-1:0] m_tuser,
    output logic                       m_tlast
);
    import pcc_pkg::*;

    function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] idx);
        logic [RING_AW-1:0] res;
        if (idx == RING_AW'(LOOKBACK_MAX - 1)) res = '0;
        else res = idx + 1'b1;
        return res;
    endfunction

    logic [CMD_W-1:0]    item_cmd_reg;
    logic [TAG_W-1:0]    item_tag_reg;
    logic                item_present_reg;

    logic [RING_AW-1:0]  ring_head_reg;
    logic [CNT_W-1:0]    ring_count_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic                clip_open_reg;
    logic [RING_AW-1:0]  rd_ptr_reg;
    logic [RING_AW-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]    flush_left_reg;

    logic [TAG_W-1:0]    ring_mem [LOOKBACK_MAX];
    logic [TAG_W-1:0]    rd_data_reg;

    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic                out_last_reg;

    logic [CNT_W-1:0]    depth_sat;
    logic                count_below;
    logic                push_do;
    logic [CNT_W:0]      head_ext;
    logic [CNT_W:0]      count_ext;
    logic [CNT_W:0]      start_sum;
    logic [RING_AW-1:0]  start_idx;
    logic                out_free;

    always_comb begin
        if ({1'b0, cfg.depth} > (DEPTH_W + 1)'(LOOKBACK_MAX)) depth_sat = CNT_W'(LOOKBACK_MAX);
        else depth_sat = CNT_W'(cfg.depth);
    end

    // A full ring (or one whose depth was lowered) still takes the tag and drops its oldest one.
    assign count_below = ring_count_reg < depth_sat;
    assign push_do     = ctl.push && (count_below || (ring_count_reg != '0));

    // Oldest entry sits count places behind the write position.
    assign head_ext  = (CNT_W + 1)'(ring_head_reg);
    assign count_ext = (CNT_W + 1)'(ring_count_reg);
    assign start_sum = (head_ext >= count_ext) ? (head_ext - count_ext)
                     : (head_ext + (CNT_W + 1)'(LOOKBACK_MAX) - count_ext);
    assign start_idx = start_sum[RING_AW-1:0];

    always_comb begin
        if (ctl.open_flush) rd_ptr_next = start_idx;
        else if (ctl.flush_adv) rd_ptr_next = ring_inc(rd_ptr_reg);
        else rd_ptr_next = rd_ptr_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctl.latch_item) begin
            item_cmd_reg     <= in_cmd;
            item_tag_reg     <= in_tag;
            item_present_reg <= in_present;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_head_reg  <= '0;
            ring_count_reg <= '0;
            frames_reg     <= '0;
            clip_open_reg  <= 1'b0;
            rd_ptr_reg     <= '0;
            flush_left_reg <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            if (push_do) ring_head_reg <= ring_inc(ring_head_reg);
            if (ctl.open_flush || ctl.close_clip) begin
                ring_count_reg <= '0;
            end else if (ctl.push && count_below) begin
                ring_count_reg <= ring_count_reg + 1'b1;
            end
            if (ctl.detect_load) begin
                frames_reg <= cfg.post_frames;
            end else if (ctl.frame_dec) begin
                frames_reg <= frames_reg - 1'b1;
            end
            if (ctl.open_flush) begin
                clip_open_reg <= 1'b1;
            end else if (ctl.close_clip) begin
                clip_open_reg <= 1'b0;
            end
            if (ctl.open_flush) begin
                flush_left_reg <= ring_count_reg;
            end else if (ctl.flush_adv) begin
                flush_left_reg <= flush_left_reg - 1'b1;
            end
        end
    end

    // Read address comes from the next pointer so the read data tracks rd_ptr_reg.
    always_ff @(posedge aclk) begin
        if (push_do) ring_mem[ring_head_reg] <= item_tag_reg;
        rd_data_reg <= ring_mem[rd_ptr_next];
    end

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            out_kind_reg <= ctl.out_kind;
            out_last_reg <= ctl.out_last;
            case (ctl.out_src)
                SRC_ITEM: out_tag_reg <= item_tag_reg;
                SRC_RING: out_tag_reg <= rd_data_reg;
                default:  out_tag_reg <= '0;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tag_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    assign st.cmd         = item_cmd_reg;
    assign st.frame_ok    = cfg.mask[0] && item_present_reg;
    assign st.detect_ok   = cfg.mask[1];
    assign st.effector_ok = cfg.mask[2];
    assign st.clip_open   = clip_open_reg;
    assign st.frames_zero = (frames_reg == '0);
    assign st.frames_one  = (frames_reg == FRAMES_W'(1));
    assign st.flush_zero  = (flush_left_reg == '0);
    assign st.flush_one   = (flush_left_reg == CNT_W'(1));
    assign st.out_free    = out_free;

endmodule

// ----- sv/pretrigger_capture_controller.sv -----
// Pretrigger capture controller: the block handles one event item at a time. A dropped
// event emits nothing; a frame, effector or detection inside an open clip emits one
// result, and a frame that closes the clip emits it and then the clip end (only the end
// when the countdown was already zero, since no frame is written then). A detection
// that opens a clip emits the clip start, a frame for each tag held in the lookback ring
// and then the detection; the ring memory has one read port and the sweep moves one tag
// per cycle unless the result channel stalls, which holds every emit state. A finished
// result waits in the output register while the next item is accepted.
// Top level; depends on pcc_pkg, pcc_regs, pcc_ctrl and pcc_dp.
module pretrigger_capture_controller (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pcc_pkg::TAG_W-1:0]   s_tdata,   // item_tag
    input  logic [pcc_pkg::SUSER_W-1:0] s_tuser,   // cmd [1:0], image_present [2]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pcc_pkg::TAG_W-1:0]   m_tdata,   // out_tag
    output logic [pcc_pkg::KIND_W-1:0]  m_tuser,   // kind [2:0]
    output logic                        m_tlast,   // last
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [pcc_pkg::DATA_W-1:0]  pwdata,
    output logic [pcc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import pcc_pkg::*;

    cfg_t         cfg;
    ctrl_cmd_t    ctl;
    ctrl_status_t st;

    pcc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .ctl      (ctl)
    );

    pcc_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .ctl        (ctl),
        .st         (st),
        .in_cmd     (s_tuser[CMD_W-1:0]),
        .in_tag     (s_tdata),
        .in_present (s_tuser[CMD_W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- sv/pcc_checker.sv -----
// Port-level checks for the pretrigger capture controller, bound to the top level.
// Depends on pcc_pkg for the result kind codes.
module pcc_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [pcc_pkg::TAG_W-1:0]  m_tdata,
    input logic [pcc_pkg::KIND_W-1:0] m_tuser,
    input logic                       m_tlast
);
    import pcc_pkg::*;

    // Each item is decoded in its own cycle before another can be taken.
    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

    a_marker_zero_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_START || m_tuser == KIND_END)) |-> (m_tdata == '0))
        else $error("clip start or end carries a nonzero tag");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_END)) |-> m_tlast)
        else $error("clip end not marked last");

    a_start_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_START)) |-> !m_tlast)
        else $error("clip start marked last");

endmodule

bind pretrigger_capture_controller pcc_checker u_pcc_checker (.*);
